[rtl/ssm_pkg.sv]
package ssm_pkg;

  localparam int PAT_MAX = 16;
  localparam int ELEM_W  = 8;
  localparam int LEN_W   = 16;

  // port widths fixed by the interface
  localparam int CMD_W   = 2;
  localparam int VALUE_W = 8;
  localparam int OUT_W   = 16;

  // pattern length runs 0..PAT_MAX
  localparam int PLEN_W  = $clog2(PAT_MAX + 1);
  localparam int CMP_W   = LEN_W + PLEN_W;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [PLEN_W-1:0] plen_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic             found;
    logic [OUT_W-1:0] first_start;
    logic [OUT_W-1:0] last_start;
    logic [OUT_W-1:0] text_length;
    logic             pattern_overflow;
    logic             text_overflow;
  } res_t;

endpackage

[rtl/ssm_core.sv]
module ssm_core
  import ssm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [CMD_W-1:0]   command,
  input  logic [VALUE_W-1:0] value,
  output logic               res_valid,
  output res_t               res
);

  // pattern held reversed: rpat[k] is pattern element plen-1-k
  elem_t rpat [PAT_MAX];
  elem_t win  [PAT_MAX];
  elem_t win_sh [PAT_MAX];
  plen_t plen;
  len_t  count;
  len_t  first;
  len_t  last;
  logic  have;
  logic  pfull;
  logic  sat;

  cmd_t  cmd;
  elem_t elem;
  logic  all_eq;
  logic  count_full;
  len_t  count_inc;
  logic  long_enough;
  logic  hit;
  len_t  start;

  assign cmd  = cmd_t'(command);
  assign elem = ELEM_W'(value);

  always_comb begin
    win_sh[0] = elem;
    for (int k = 1; k < PAT_MAX; k++) begin
      win_sh[k] = win[k-1];
    end
  end

  always_comb begin
    all_eq = 1'b1;
    for (int k = 0; k < PAT_MAX; k++) begin
      if ((PLEN_W'(k) < plen) && (rpat[k] != win_sh[k])) begin
        all_eq = 1'b0;
      end
    end
  end

  assign count_full  = (count == {LEN_W{1'b1}});
  assign count_inc   = count + 1'b1;
  assign long_enough = CMP_W'(count_inc) >= CMP_W'(plen);
  assign hit         = (plen != '0) && long_enough && all_eq;
  assign start       = count_inc - LEN_W'(plen);

  // summary of the text so far
  always_comb begin
    res.found            = (plen == '0) ? 1'b1 : have;
    res.first_start      = (plen != '0 && have) ? OUT_W'(first) : '0;
    res.last_start       = (plen == '0) ? OUT_W'(count) : (have ? OUT_W'(last) : '0);
    res.text_length      = OUT_W'(count);
    res.pattern_overflow = pfull;
    res.text_overflow    = sat;
  end

  assign res_valid = take && (cmd == CMD_END);

  // pattern store has no reset
  always_ff @(posedge clk) begin
    if (take && cmd == CMD_APPEND && plen < PLEN_W'(PAT_MAX)) begin
      rpat[0] <= elem;
      for (int k = 1; k < PAT_MAX; k++) begin
        rpat[k] <= rpat[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen  <= '0;
      pfull <= 1'b0;
      count <= '0;
      have  <= 1'b0;
      first <= '0;
      last  <= '0;
      sat   <= 1'b0;
      for (int k = 0; k < PAT_MAX; k++) begin
        win[k] <= '0;
      end
    end else if (take) begin
      unique case (cmd)
        CMD_CLEAR, CMD_END: begin
          if (cmd == CMD_CLEAR) begin
            plen  <= '0;
            pfull <= 1'b0;
          end
          count <= '0;
          have  <= 1'b0;
          first <= '0;
          last  <= '0;
          sat   <= 1'b0;
          for (int k = 0; k < PAT_MAX; k++) begin
            win[k] <= '0;
          end
        end
        CMD_APPEND: begin
          if (plen < PLEN_W'(PAT_MAX)) begin
            plen <= plen + 1'b1;
          end else begin
            pfull <= 1'b1;
          end
        end
        CMD_TEXT: begin
          if (count_full) begin
            sat <= 1'b1;
          end else begin
            count <= count_inc;
            for (int k = 0; k < PAT_MAX; k++) begin
              win[k] <= win_sh[k];
            end
            if (hit) begin
              if (!have) begin
                first <= start;
              end
              last <= start;
              have <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/ssm_out_buf.sv]
module ssm_out_buf
  import ssm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_res,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_res
);

  res_t skid_res;
  logic skid_valid;
  logic pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_res <= skid_valid ? skid_res : push_res;
    end
    if (push) begin
      skid_res <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

endmodule

[rtl/substring_first_last_match_unit.sv]
// each result word is registered, in the output register or else in the skid entry
// one word per cycle unless stalled; the window compare finishes in the accept cycle
// the output register plus one skid entry hold results while the output stalls
// rst is synchronous, active high: empty pattern, empty text, no result pending
// pattern store contents are not reset and only entries below the pattern length are used
module substring_first_last_match_unit
  import ssm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   command,
  input  logic [VALUE_W-1:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               found,
  output logic [OUT_W-1:0]   first_start,
  output logic [OUT_W-1:0]   last_start,
  output logic [OUT_W-1:0]   text_length,
  output logic               pattern_overflow,
  output logic               text_overflow
);

  logic take;
  logic res_valid;
  res_t res;
  res_t out_res;
  logic buf_full;

  // stall only when the skid entry is occupied, so any accepted word has room
  assign in_stall = buf_full;
  assign take     = in_valid && !in_stall;

  // pattern and text state, window compare and summary
  ssm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .command   (command),
    .value     (value),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register with skid entry
  ssm_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_res  (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign found            = out_res.found;
  assign first_start      = out_res.first_start;
  assign last_start       = out_res.last_start;
  assign text_length      = out_res.text_length;
  assign pattern_overflow = out_res.pattern_overflow;
  assign text_overflow    = out_res.text_overflow;

`ifndef NO_ASSERTIONS
  // input can only back up while a result is waiting at the output
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // an accepted end-of-text word always shows up at the output
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && command == CMD_END) |=> out_valid)
    else $error("end of text produced no result");

  // a second result while one waits fills the skid entry
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && command == CMD_END && out_valid && out_stall) |=> in_stall)
    else $error("queued result not held");
`endif

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssm_pkg::*;

  // largest count the text counter can hold before it saturates
  localparam int unsigned COUNT_TOP = (1 << LEN_W) - 1;
  // cycles without any accepted word before the run is declared hung
  localparam int QUIET_LIMIT = 1000;
  // extra cycles after the last summary
  localparam int TAIL_CYCLES = 8;

  // tracks pattern, text window and match records, and queues the summary
  // word that each end-of-text command must produce
  class search_tracker;
    elem_t       pat [PAT_MAX];
    int unsigned pat_len;
    elem_t       win [PAT_MAX];
    int unsigned seen_count;
    bit          hit;
    int unsigned first_at;
    int unsigned last_at;
    bit          pat_full;
    bit          count_sat;
    res_t        summaries_due[$];
    int          errors;

    function new();
      pat_len  = 0;
      pat_full = 0;
      errors   = 0;
      restart_text();
    endfunction

    function void restart_text();
      foreach (win[i]) win[i] = '0;
      seen_count = 0;
      hit        = 0;
      first_at   = 0;
      last_at    = 0;
      count_sat  = 0;
    endfunction

    // newest pat_len window entries against the whole pattern
    function bit window_hit();
      for (int j = 0; j < pat_len; j++)
        if (pat[j] != win[pat_len - 1 - j]) return 0;
      return 1;
    endfunction

    function void take_word(cmd_t c, elem_t v);
      res_t r;
      case (c)
        CMD_CLEAR: begin
          pat_len  = 0;
          pat_full = 0;
          restart_text();
        end
        CMD_APPEND: begin
          if (pat_len < PAT_MAX) begin
            pat[pat_len] = v;
            pat_len++;
          end else begin
            pat_full = 1;
          end
        end
        CMD_TEXT: begin
          if (seen_count == COUNT_TOP) begin
            count_sat = 1;
          end else begin
            seen_count++;
            for (int i = PAT_MAX - 1; i > 0; i--) win[i] = win[i - 1];
            win[0] = v;
            if (pat_len > 0 && seen_count >= pat_len && window_hit()) begin
              if (!hit) first_at = seen_count - pat_len;
              last_at = seen_count - pat_len;
              hit     = 1;
            end
          end
        end
        default: begin
          r.found            = (pat_len == 0) || hit;
          r.first_start      = hit ? OUT_W'(first_at) : '0;
          r.last_start       = (pat_len == 0) ? OUT_W'(seen_count) :
                               (hit ? OUT_W'(last_at) : '0);
          r.text_length      = OUT_W'(seen_count);
          r.pattern_overflow = pat_full;
          r.text_overflow    = count_sat;
          summaries_due.push_back(r);
          restart_text();
        end
      endcase
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_summary(res_t got);
      res_t want;
      if (summaries_due.size() == 0) begin
        errors++;
        $display("%0t: summary word with none expected, actual found %0d first %0d last %0d len %0d",
                 $time, got.found, got.first_start, got.last_start, got.text_length);
        return;
      end
      want = summaries_due.pop_front();
      check_field("found", want.found, got.found);
      check_field("first_start", want.first_start, got.first_start);
      check_field("last_start", want.last_start, got.last_start);
      check_field("text_length", want.text_length, got.text_length);
      check_field("pattern_overflow", want.pattern_overflow, got.pattern_overflow);
      check_field("text_overflow", want.text_overflow, got.text_overflow);
    endfunction
  endclass

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   command   = CMD_CLEAR;
  logic [VALUE_W-1:0] value     = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               found;
  logic [OUT_W-1:0]   first_start;
  logic [OUT_W-1:0]   last_start;
  logic [OUT_W-1:0]   text_length;
  logic               pattern_overflow;
  logic               text_overflow;

  // idle and stall odds in percent, changed between phases
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int words_sent    = 0;
  int quiet_cycles  = 0;

  search_tracker tracker = new();

  substring_first_last_match_unit u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver side: random stall, decided at the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  // sample both handshakes at the rising edge, before the block updates
  always @(posedge clk) begin
    res_t seen;
    if (!rst) begin
      if (in_valid && !in_stall)
        tracker.take_word(cmd_t'(command), value[ELEM_W-1:0]);
      if (out_valid && !out_stall) begin
        seen.found            = found;
        seen.first_start      = first_start;
        seen.last_start       = last_start;
        seen.text_length      = text_length;
        seen.pattern_overflow = pattern_overflow;
        seen.text_overflow    = text_overflow;
        tracker.check_summary(seen);
      end
    end
  end

  // watchdog: any accepted word on either side restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance;
  // valid stays high between back-to-back words, payload is noise while idle
  task automatic send_word(cmd_t c, elem_t v);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      command  <= CMD_W'($urandom_range(0, 3));
      value    <= VALUE_W'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= c;
    value    <= VALUE_W'(v);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // small alphabet keeps matches frequent
  function automatic elem_t pick_elem(elem_t a, elem_t b);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return a;
    if (roll < 70) return b;
    return elem_t'($urandom);
  endfunction

  task automatic run_directed();
    // empty pattern and empty text
    send_word(CMD_END, 8'h00);
    // empty pattern over a short text: last start equals the length
    send_word(CMD_TEXT, 8'h00);
    send_word(CMD_TEXT, 8'hFF);
    send_word(CMD_END, 8'hFF);
    // pattern longer than the text so far never matches
    send_word(CMD_APPEND, 8'hFF);
    send_word(CMD_APPEND, 8'h00);
    send_word(CMD_TEXT, 8'hFF);
    send_word(CMD_END, 8'h00);
    // repeated matches, first and last differ
    send_word(CMD_TEXT, 8'hFF);
    send_word(CMD_TEXT, 8'h00);
    send_word(CMD_TEXT, 8'hFF);
    send_word(CMD_TEXT, 8'h00);
    send_word(CMD_TEXT, 8'hFF);
    send_word(CMD_END, 8'h00);
    // append while a text is in progress
    send_word(CMD_TEXT, 8'hFF);
    send_word(CMD_APPEND, 8'h5A);
    send_word(CMD_TEXT, 8'h00);
    send_word(CMD_TEXT, 8'h5A);
    send_word(CMD_TEXT, 8'h11);
    send_word(CMD_END, 8'h00);
    // clear drops the text in progress too
    send_word(CMD_TEXT, 8'h12);
    send_word(CMD_CLEAR, 8'hA5);
    send_word(CMD_END, 8'h00);
    // fill the pattern and one more: the extra append is dropped and flagged
    for (int i = 0; i < PAT_MAX + 1; i++) send_word(CMD_APPEND, elem_t'(i * 15));
    for (int i = 0; i < PAT_MAX; i++) send_word(CMD_TEXT, elem_t'(i * 15));
    send_word(CMD_END, 8'h00);
    // flag outlives end of text, goes away on clear
    send_word(CMD_END, 8'h00);
    send_word(CMD_CLEAR, 8'h00);
    send_word(CMD_END, 8'h00);
  endtask

  // mostly well-formed searches: new pattern, text with planted copies,
  // end of text; a few bursts of arbitrary commands in between
  task automatic run_random(int n);
    int    target;
    int    roll;
    int    k;
    int    len;
    elem_t a;
    elem_t b;
    target = words_sent + n;
    while (words_sent < target) begin
      a    = elem_t'($urandom);
      b    = elem_t'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        repeat ($urandom_range(1, 6))
          send_word(cmd_t'($urandom_range(0, 3)), elem_t'($urandom));
      end else begin
        if (roll < 80) send_word(CMD_CLEAR, elem_t'($urandom));
        roll = $urandom_range(0, 99);
        if (roll < 10)      k = 0;
        else if (roll < 85) k = $urandom_range(1, 4);
        else if (roll < 95) k = $urandom_range(5, PAT_MAX);
        else                k = $urandom_range(PAT_MAX + 1, PAT_MAX + 4);
        repeat (k) send_word(CMD_APPEND, pick_elem(a, b));
        len = $urandom_range(0, 30);
        for (int j = 0; j < len; j++) begin
          roll = $urandom_range(0, 99);
          if (roll < 15) begin
            // plant a full copy of the current pattern
            for (int i = 0; i < tracker.pat_len; i++) send_word(CMD_TEXT, tracker.pat[i]);
          end else if (roll < 18) begin
            send_word(CMD_APPEND, pick_elem(a, b));
          end else if (roll < 19) begin
            send_word(CMD_CLEAR, elem_t'($urandom));
          end else begin
            send_word(CMD_TEXT, pick_elem(a, b));
          end
        end
        send_word(CMD_END, elem_t'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // no idling on either side
    run_directed();
    run_random(370);

    // sender mostly idle
    in_idle_pct = 68;
    run_random(370);

    // receiver mostly stalling
    in_idle_pct   = 0;
    out_stall_pct = 68;
    run_random(370);

    // both sides idle now and then
    in_idle_pct   = 38;
    out_stall_pct = 38;
    run_random(370);

    in_valid <= 1'b0;
    while (tracker.summaries_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
